>>> design/flr_pkg.sv
// Shared constants, types and functions of the filtered line resampler.
package flr_pkg;

  localparam int unsigned MAX_LEN      = 1024;
  localparam int unsigned POS_W        = 10;
  localparam int unsigned LEN_W        = 11;
  localparam int unsigned CH_W         = 8;
  localparam int unsigned PIX_W        = 3 * CH_W;
  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned MAX_RADIUS   = 8;
  localparam int unsigned RAD_W        = 4;
  localparam int unsigned WGT_W        = 16;
  localparam int unsigned WGT_ADDR_W   = 11;
  // Distances at or beyond this count give a Gaussian weight of zero.
  localparam int unsigned WGT_COUNT    = 1774;
  localparam int unsigned DIST_W       = 12;
  localparam int unsigned X_W          = 28;
  localparam int unsigned NUM_W        = 29;
  localparam int unsigned DEN_W        = 12;
  localparam int unsigned TAYLOR_ORDER = 12;
  localparam int unsigned T_W          = 37;

  localparam logic [T_W-1:0] LN2_Q32          = 37'd2977044472;
  localparam logic [31:0]    INV_SQRT_2PI_Q32 = 32'd1713444047;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_COMPUTE = 1'b1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

  // floor(2^32 / i) for the Taylor term divisors.
  function automatic logic [31:0] recip_q32(input logic [3:0] i);
    logic [31:0] r;
    unique case (i)
      4'd2:    r = 32'd2147483648;
      4'd3:    r = 32'd1431655765;
      4'd4:    r = 32'd1073741824;
      4'd5:    r = 32'd858993459;
      4'd6:    r = 32'd715827882;
      4'd7:    r = 32'd613566756;
      4'd8:    r = 32'd536870912;
      4'd9:    r = 32'd477218588;
      4'd10:   r = 32'd429496729;
      4'd11:   r = 32'd390451572;
      4'd12:   r = 32'd357913941;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> design/flr_line_store.sv
// Source line memory: one write port and one registered read port.
module flr_line_store (
  input  logic                       clk_i,
  input  logic                       wr_en_i,
  input  logic [flr_pkg::POS_W-1:0]  wr_addr_i,
  input  logic [flr_pkg::PIX_W-1:0]  wr_data_i,
  input  logic [flr_pkg::POS_W-1:0]  rd_addr_i,
  output logic [flr_pkg::PIX_W-1:0]  rd_data_o
);

  logic [flr_pkg::PIX_W-1:0] mem_q [flr_pkg::MAX_LEN];
  logic [flr_pkg::PIX_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

>>> design/flr_pos_div.sv
// Restoring divider for the sample position, one quotient bit per cycle.
module flr_pos_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  flr_pkg::div_req_t req_i,
  output flr_pkg::div_rsp_t rsp_o
);

  localparam int unsigned CNT_W = $clog2(flr_pkg::NUM_W);

  logic                      busy_q;
  logic                      done_q;
  logic [CNT_W-1:0]          cnt_q;
  logic [flr_pkg::DEN_W-1:0] rem_q;
  logic [flr_pkg::DEN_W-1:0] den_q;
  logic [flr_pkg::NUM_W-1:0] quot_q;
  logic [flr_pkg::DEN_W:0]   trial;
  logic                      fits;

  assign trial = {rem_q, quot_q[flr_pkg::NUM_W-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(flr_pkg::NUM_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= '0;
      den_q  <= req_i.den;
      quot_q <= req_i.num;
    end else if (busy_q) begin
      if (fits) begin
        rem_q <= flr_pkg::DEN_W'(trial - {1'b0, den_q});
      end else begin
        rem_q <= trial[flr_pkg::DEN_W-1:0];
      end
      quot_q <= {quot_q[flr_pkg::NUM_W-2:0], fits};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

>>> design/flr_weight_table.sv
// Gaussian weight table: filled after reset by a sequential evaluator, then read per tap.
module flr_weight_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [flr_pkg::WGT_ADDR_W-1:0] rd_addr_i,
  output logic [flr_pkg::WGT_W-1:0]      rd_data_o,
  output logic                           ready_o
);

  typedef enum logic [8:0] {
    W_SQUARE = 9'b000000001,
    W_LOG    = 9'b000000010,
    W_INIT   = 9'b000000100,
    W_MUL    = 9'b000001000,
    W_RECIP  = 9'b000010000,
    W_FIX    = 9'b000100000,
    W_SCALE  = 9'b001000000,
    W_WRITE  = 9'b010000000,
    W_DONE   = 9'b100000000
  } wstate_e;

  wstate_e state_q, state_d;

  logic [flr_pkg::WGT_ADDR_W-1:0] d_q;
  logic [flr_pkg::T_W-1:0]        rem_q;
  logic [5:0]                     n_q;
  logic [2:0]                     step_q;
  logic [31:0]                    term_q;
  logic [31:0]                    a_q;
  logic [31:0]                    qe_q;
  logic [32:0]                    sum_q;
  logic [3:0]                     i_q;
  logic [63:0]                    prod_q;

  logic [flr_pkg::WGT_W-1:0] mem_q [1 << flr_pkg::WGT_ADDR_W];
  logic [flr_pkg::WGT_W-1:0] rd_q;

  logic [21:0]             sq;
  logic [flr_pkg::T_W-1:0] ln2_sh;
  logic [63:0]             mul_term;
  logic [63:0]             mul_recip;
  logic [35:0]             qe_i;
  logic [35:0]             chk;
  logic [31:0]             q_fix;
  logic [32:0]             e_val;
  logic [63:0]             mul_scale;
  logic [63:0]             w_round;

  always_comb begin
    sq        = 22'(d_q) * 22'(d_q);
    ln2_sh    = flr_pkg::LN2_Q32 << step_q;
    mul_term  = 64'(term_q) * 64'(rem_q[31:0]);
    mul_recip = 64'(a_q) * 64'(flr_pkg::recip_q32(i_q));
    qe_i      = 36'(qe_q) * 36'(i_q);
    chk       = 36'(a_q) - qe_i;
    q_fix     = qe_q + 32'(chk >= 36'(i_q));
    e_val     = sum_q >> n_q;
    mul_scale = 64'(e_val) * 64'(flr_pkg::INV_SQRT_2PI_Q32);
    w_round   = prod_q + (64'd1 << (63 - flr_pkg::WGT_W));
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      W_SQUARE: state_d = W_LOG;
      W_LOG: begin
        if (step_q == '0) begin
          state_d = W_INIT;
        end
      end
      W_INIT:  state_d = W_MUL;
      W_MUL:   state_d = W_RECIP;
      W_RECIP: state_d = W_FIX;
      W_FIX: begin
        if (i_q == 4'(flr_pkg::TAYLOR_ORDER)) begin
          state_d = W_SCALE;
        end else begin
          state_d = W_MUL;
        end
      end
      W_SCALE: state_d = W_WRITE;
      W_WRITE: begin
        if (d_q == flr_pkg::WGT_ADDR_W'(flr_pkg::WGT_COUNT - 1)) begin
          state_d = W_DONE;
        end else begin
          state_d = W_SQUARE;
        end
      end
      W_DONE:  state_d = W_DONE;
      default: state_d = W_SQUARE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= W_SQUARE;
      d_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == W_WRITE) begin
        d_q <= d_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      W_SQUARE: begin
        rem_q  <= {sq, 15'b0};
        n_q    <= '0;
        step_q <= 3'd5;
      end
      W_LOG: begin
        if (rem_q >= ln2_sh) begin
          rem_q       <= rem_q - ln2_sh;
          n_q[step_q] <= 1'b1;
        end
        step_q <= step_q - 1'b1;
      end
      W_INIT: begin
        term_q <= rem_q[31:0];
        sum_q  <= (33'd1 << 32) - 33'(rem_q[31:0]);
        i_q    <= 4'd2;
      end
      W_MUL:   a_q  <= mul_term[63:32];
      W_RECIP: qe_q <= mul_recip[63:32];
      W_FIX: begin
        term_q <= q_fix;
        if (i_q[0]) begin
          sum_q <= sum_q - 33'(q_fix);
        end else begin
          sum_q <= sum_q + 33'(q_fix);
        end
        i_q <= i_q + 1'b1;
      end
      W_SCALE: prod_q <= mul_scale;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == W_WRITE) begin
      mem_q[d_q] <= w_round[63:64-flr_pkg::WGT_W];
    end
    rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;
  assign ready_o   = state_q == W_DONE;

endmodule

>>> design/filtered_line_resampler.sv
// Top level of the filtered line resampler: register port, tap sequencer and output stage.
//
//   Channel  | Direction | Payload
//   s_axis   | in        | tuser: operation; tdata: position, red_in, green_in, blue_in
//   m_axis   | out       | tdata: out_position, red_out, green_out, blue_out
//   APB      | in/out    | input_length, output_length, filter_mode, filter_radius
//
// A load transfer is written into the line store when it is accepted. A compute transfer
// runs the 29-step position divider, then reads its taps one at a time through the single
// line store read port. After reset the weight table is filled with s_axis_tready low;
// register writes are taken throughout. A stalled result waits in the output register
// while the next transfer is accepted.
module filtered_line_resampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // position, red_in, green_in, blue_in, zero pad
  input  logic        s_axis_tuser,  // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_position, red_out, green_out, blue_out, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_INPUT_LENGTH  = 2'd0;
  localparam logic [1:0] REG_OUTPUT_LENGTH = 2'd1;
  localparam logic [1:0] REG_FILTER_MODE   = 2'd2;
  localparam logic [1:0] REG_FILTER_RADIUS = 2'd3;

  localparam int unsigned LEN_W = flr_pkg::LEN_W;
  localparam int unsigned POS_W = flr_pkg::POS_W;
  localparam int unsigned CH_W  = flr_pkg::CH_W;
  localparam int unsigned X_W   = flr_pkg::X_W;
  localparam int unsigned FB    = flr_pkg::FRAC_BITS;

  typedef enum logic [6:0] {
    ST_IDLE     = 7'b0000001,
    ST_DIVSTART = 7'b0000010,
    ST_DIVWAIT  = 7'b0000100,
    ST_RANGE    = 7'b0001000,
    ST_TAP      = 7'b0010000,
    ST_DRAIN    = 7'b0100000,
    ST_EMIT     = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [LEN_W-1:0]         in_len_q;
  logic [LEN_W-1:0]         out_len_q;
  logic                     mode_q;
  logic [flr_pkg::RAD_W-1:0] radius_q;

  logic [POS_W-1:0] pos_q;
  logic [X_W-1:0]   x_q;
  logic [LEN_W-1:0] k_q;
  logic [LEN_W-1:0] hi_q;
  logic             tap_vld_q;
  logic             tap_zero_q;
  logic             tap_far_q;
  logic [CH_W-1:0]  sum_q [3];

  logic             m_valid_q;
  logic [POS_W-1:0] m_pos_q;
  logic [CH_W-1:0]  m_ch_q [3];

  logic                      cfg_wr;
  logic                      s_acc;
  logic [LEN_W-1:0]          eff_ilen;
  logic [LEN_W-1:0]          eff_olen;
  logic [flr_pkg::RAD_W-1:0] eff_rad;
  logic [21:0]               span_prod;
  flr_pkg::div_req_t         div_req;
  flr_pkg::div_rsp_t         div_rsp;

  logic [X_W-1:0]   rad_fx;
  logic [X_W-1:0]   x_lo;
  logic [19:0]      lo;
  logic [X_W:0]     hi_sum;
  logic [20:0]      hi_full;
  logic [LEN_W-1:0] hi_clip;
  logic             range_empty;

  logic [X_W-1:0]            kp;
  logic [X_W-1:0]            d_full;
  logic [flr_pkg::DIST_W-1:0] tap_d;
  logic [LEN_W-1:0]          k_next;

  logic [flr_pkg::PIX_W-1:0] pix_rd;
  logic [flr_pkg::WGT_W-1:0] wgt_rd;
  logic [flr_pkg::WGT_W-1:0] w_eff;
  logic                      tbl_ready;
  logic [CH_W-1:0]           pix_ch [3];
  logic [23:0]               ch_prod [3];
  logic [CH_W-1:0]           contrib [3];
  logic                      out_load;

  // Register port.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_len_q  <= LEN_W'(flr_pkg::MAX_LEN);
      out_len_q <= LEN_W'(flr_pkg::MAX_LEN);
      mode_q    <= 1'b0;
      radius_q  <= flr_pkg::RAD_W'(1);
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_INPUT_LENGTH:  in_len_q  <= pwdata[LEN_W-1:0];
        REG_OUTPUT_LENGTH: out_len_q <= pwdata[LEN_W-1:0];
        REG_FILTER_MODE:   mode_q    <= pwdata[0];
        REG_FILTER_RADIUS: radius_q  <= pwdata[flr_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_INPUT_LENGTH:  prdata = 32'(in_len_q);
      REG_OUTPUT_LENGTH: prdata = 32'(out_len_q);
      REG_FILTER_MODE:   prdata = 32'(mode_q);
      REG_FILTER_RADIUS: prdata = 32'(radius_q);
      default:           prdata = '0;
    endcase
  end

  // Effective configuration and position arithmetic.
  always_comb begin
    eff_ilen = (in_len_q > LEN_W'(flr_pkg::MAX_LEN)) ? LEN_W'(flr_pkg::MAX_LEN) : in_len_q;
    eff_olen = (out_len_q == '0) ? LEN_W'(1) : out_len_q;
    eff_rad  = (radius_q > flr_pkg::RAD_W'(flr_pkg::MAX_RADIUS)) ?
               flr_pkg::RAD_W'(flr_pkg::MAX_RADIUS) : radius_q;

    span_prod     = 22'({pos_q, 1'b1}) * 22'(eff_ilen);
    div_req.start = state_q == ST_DIVSTART;
    div_req.num   = {span_prod[20:0], 8'b0};
    div_req.den   = {eff_olen, 1'b0};

    rad_fx      = X_W'(eff_rad) << FB;
    x_lo        = (x_q >= rad_fx) ? x_q - rad_fx : '0;
    lo          = x_lo[X_W-1:FB];
    hi_sum      = (X_W+1)'(x_q) + ((X_W+1)'(eff_rad) + (X_W+1)'(1) << FB);
    hi_full     = hi_sum[X_W:FB];
    hi_clip     = (hi_full > 21'(eff_ilen)) ? eff_ilen : hi_full[LEN_W-1:0];
    range_empty = 21'(lo) >= 21'(hi_clip);

    kp     = X_W'(k_q) << FB;
    d_full = (kp >= x_q) ? kp - x_q : x_q - kp;
    tap_d  = d_full[flr_pkg::DIST_W-1:0];
    k_next = k_q + 1'b1;
  end

  flr_pos_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  flr_line_store u_line (
    .clk_i     (clk_i),
    .wr_en_i   (s_acc && (s_axis_tuser == flr_pkg::OP_LOAD)),
    .wr_addr_i (s_axis_tdata[POS_W-1:0]),
    .wr_data_i ({s_axis_tdata[POS_W+CH_W-1:POS_W],
                 s_axis_tdata[POS_W+2*CH_W-1:POS_W+CH_W],
                 s_axis_tdata[POS_W+3*CH_W-1:POS_W+2*CH_W]}),
    .rd_addr_i (k_q[POS_W-1:0]),
    .rd_data_o (pix_rd)
  );

  flr_weight_table u_wgt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (tap_d[flr_pkg::WGT_ADDR_W-1:0]),
    .rd_data_o (wgt_rd),
    .ready_o   (tbl_ready)
  );

  // Sequencer.
  assign s_axis_tready = (state_q == ST_IDLE) && tbl_ready;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_EMIT) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_acc && (s_axis_tuser == flr_pkg::OP_COMPUTE)) begin
          state_d = ST_DIVSTART;
        end
      end
      ST_DIVSTART: state_d = ST_DIVWAIT;
      ST_DIVWAIT: begin
        if (div_rsp.done) begin
          state_d = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (range_empty) begin
          state_d = ST_EMIT;
        end else begin
          state_d = ST_TAP;
        end
      end
      ST_TAP: begin
        if (k_next == hi_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      tap_vld_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      tap_vld_q <= state_q == ST_TAP;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Tap accumulation.
  always_comb begin
    w_eff     = tap_far_q ? '0 : wgt_rd;
    pix_ch[0] = pix_rd[3*CH_W-1:2*CH_W];
    pix_ch[1] = pix_rd[2*CH_W-1:CH_W];
    pix_ch[2] = pix_rd[CH_W-1:0];
    for (int c = 0; c < 3; c++) begin
      ch_prod[c] = 24'(pix_ch[c]) * 24'(w_eff);
      if (mode_q) begin
        contrib[c] = tap_zero_q ? pix_ch[c] : '0;
      end else begin
        contrib[c] = ch_prod[c][23:16];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      pos_q <= s_axis_tdata[POS_W-1:0];
    end
    if (div_rsp.done) begin
      x_q <= div_rsp.quot[X_W-1:0];
    end
    if (state_q == ST_RANGE) begin
      k_q  <= lo[LEN_W-1:0];
      hi_q <= hi_clip;
    end else if (state_q == ST_TAP) begin
      k_q <= k_next;
    end
    tap_zero_q <= d_full == '0;
    tap_far_q  <= tap_d >= flr_pkg::DIST_W'(flr_pkg::WGT_COUNT);
    for (int c = 0; c < 3; c++) begin
      if (state_q == ST_RANGE) begin
        sum_q[c] <= '0;
      end else if (tap_vld_q) begin
        sum_q[c] <= sum_q[c] + contrib[c];
      end
    end
    if (out_load) begin
      m_pos_q <= pos_q;
      for (int c = 0; c < 3; c++) begin
        m_ch_q[c] <= sum_q[c];
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_ch_q[2], m_ch_q[1], m_ch_q[0], m_pos_q};

`ifndef NO_ASSERTIONS
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !s_axis_tready)
    else $error("input ready while a compute is in flight");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIVWAIT))
    else $error("divider finished outside the wait state");

  a_tap_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TAP) |-> (k_q < hi_q))
    else $error("tap index past the end of the support");

  a_tap_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tap_vld_q |-> $past(state_q == ST_TAP))
    else $error("accumulation without a preceding tap read");
`endif

endmodule
